// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the scheduler RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define LDS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define LDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/ldsch_pkg.sv -----
// Types and constants of the LOOK disk scheduler.
// No dependencies; imported by every module of the block but the RAM.
package ldsch_pkg;

  localparam int unsigned TRACK_W   = 16;
  localparam int unsigned TOTAL_W   = 22;
  // holds a request count up to the largest supported batch
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD = 1'b0,
    REG_PREV = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    F_LOAD,
    F_WAIT,
    F_DRAIN
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_WAIT,
    B_HOLD
  } back_state_e;

  // One closed batch, sorted ascending in one RAM bank.
  typedef struct packed {
    logic               bank;
    logic [CNT_W-1:0]   n_below;
    logic [CNT_W-1:0]   n_above;
    logic [CNT_W-1:0]   base_above;
    logic [TRACK_W-1:0] head;
    logic               up;
    logic               ovf;
  } desc_t;

endpackage

// ----- rtl/look_disk_scheduler_core.sv -----
// LOOK disk scheduler. Requests load at one per cycle while full is low. After
// the last request of a batch, a wait state (held while the batch queue is full)
// and a drain state move the stored requests into RAM while the input stalls.
// Each move is read from RAM, registered, and held on the ports until popped; the
// next move is not formed before then. The next batch loads while this one is served.
// Reset clears all control state; the request RAM is not.
`include "assert_macros.svh"
module look_disk_scheduler_core #(
  parameter int unsigned MaxReq = 64,
  localparam int unsigned AW = $clog2(MaxReq)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ldsch_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ldsch_pkg::TRACK_W-1:0]   cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  logic [ldsch_pkg::TRACK_W-1:0]   track_i,
  input  logic                            last_request_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [ldsch_pkg::TRACK_W-1:0]   from_track_o,
  output logic [ldsch_pkg::TRACK_W-1:0]   to_track_o,
  output logic [ldsch_pkg::TRACK_W-1:0]   distance_o,
  output logic [ldsch_pkg::TOTAL_W-1:0]   running_total_o,
  output logic                            last_move_o,
  output logic                            dropped_o
);
  import ldsch_pkg::*;

  logic [TRACK_W-1:0] head_q, prev_q;
  logic               q_push, q_full, q_valid, q_release;
  desc_t              q_desc_in, q_head;
  logic               ram_we;
  logic [AW:0]        ram_waddr, ram_raddr;
  logic [TRACK_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      prev_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_HEAD) head_q <= cfg_wdata_i;
      if (cfg_idx_i == REG_PREV) prev_q <= cfg_wdata_i;
    end
  end

  ldsch_front #(.MaxReq(MaxReq)) u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .track_i,
    .last_request_i,
    .head_i      (head_q),
    .prev_i      (prev_q),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_desc_o    (q_desc_in),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  ldsch_desc_q u_queue (
    .clk_i,
    .rst_ni,
    .push_i    (q_push),
    .desc_i    (q_desc_in),
    .full_o    (q_full),
    .valid_o   (q_valid),
    .head_o    (q_head),
    .release_i (q_release)
  );

  // Two banks: one batch drains while the previous one is served.
  ldsch_ram #(.Width(TRACK_W), .Depth(2 ** (AW + 1))) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ldsch_back #(.MaxReq(MaxReq)) u_back (
    .clk_i,
    .rst_ni,
    .d_valid_i   (q_valid),
    .desc_i      (q_head),
    .release_o   (q_release),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .empty,
    .pop,
    .from_track_o,
    .to_track_o,
    .distance_o,
    .running_total_o,
    .last_move_o,
    .dropped_o
  );

  `LDS_ASSERT(a_no_q_overrun, clk_i, rst_ni, q_push |-> !q_full, "batch queue overrun")
  `LDS_ASSERT(a_result_has_batch, clk_i, rst_ni, !empty |-> q_valid, "result without batch")
  `LDS_ASSERT(a_last_drains, clk_i, rst_ni, pop && !empty && last_move_o |=> empty, "late move")
  `LDS_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> empty, "result visible in reset")

endmodule

// ----- rtl/ldsch_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ldsch_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ldsch_front.sv -----
// Front end: insertion-sort chain that loads requests, then drains a closed
// batch into a RAM bank while classifying it against the head track.
// Depends on ldsch_pkg.
module ldsch_front #(
  parameter int unsigned MaxReq = 64,
  localparam int unsigned AW = $clog2(MaxReq)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [ldsch_pkg::TRACK_W-1:0] track_i,
  input  logic                        last_request_i,
  input  logic [ldsch_pkg::TRACK_W-1:0] head_i,
  input  logic [ldsch_pkg::TRACK_W-1:0] prev_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output ldsch_pkg::desc_t            q_desc_o,
  output logic                        ram_we_o,
  output logic [AW:0]                 ram_waddr_o,
  output logic [ldsch_pkg::TRACK_W-1:0] ram_wdata_o
);
  import ldsch_pkg::*;

  localparam int unsigned CW = $clog2(MaxReq + 1);

  front_state_e state_q, state_d;

  logic [TRACK_W-1:0] val_q [MaxReq];
  logic [TRACK_W-1:0] ins_val [MaxReq];
  logic [MaxReq-1:0]  vld_q, ins_vld, le;

  logic [CW-1:0]    cnt_q, didx_q;
  logic [CNT_W-1:0] nb_q, ne_q, nb_fin, ne_fin;
  logic             ovf_q, bank_q;
  logic             accept, ins_en, shift_en, drain_end, is_below, is_eq;

  // Each cell keeps its value, takes the new track, or takes its lower neighbor's.
  for (genvar g = 0; g < MaxReq; g++) begin : g_cell
    assign le[g] = vld_q[g] && (val_q[g] <= track_i);
    if (g == 0) begin : g_first
      assign ins_val[g] = le[g] ? val_q[g] : track_i;
      assign ins_vld[g] = 1'b1;
    end else begin : g_rest
      assign ins_val[g] = le[g] ? val_q[g] : (le[g-1] ? track_i : val_q[g-1]);
      assign ins_vld[g] = vld_q[g] | vld_q[g-1];
    end
  end

  assign accept    = push && !full;
  assign drain_end = (state_q == F_DRAIN) && (didx_q == CW'(cnt_q - 1'b1));
  assign is_below  = val_q[0] < head_i;
  assign is_eq     = val_q[0] == head_i;
  assign nb_fin    = nb_q + CNT_W'(is_below);
  assign ne_fin    = ne_q + CNT_W'(is_eq);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_LOAD:  if (accept && last_request_i) state_d = F_WAIT;
      F_WAIT:  if (!q_full_i) state_d = F_DRAIN;
      F_DRAIN: if (drain_end) state_d = F_LOAD;
      default: state_d = F_LOAD;
    endcase
  end

  always_comb begin
    full        = state_q != F_LOAD;
    ins_en      = accept && (cnt_q < CW'(MaxReq));
    shift_en    = state_q == F_DRAIN;
    ram_we_o    = shift_en;
    ram_waddr_o = {bank_q, didx_q[AW-1:0]};
    ram_wdata_o = val_q[0];
    q_push_o    = drain_end;
    q_desc_o.bank       = bank_q;
    q_desc_o.n_below    = nb_fin;
    q_desc_o.n_above    = CNT_W'(cnt_q) - nb_fin - ne_fin;
    q_desc_o.base_above = nb_fin + ne_fin;
    q_desc_o.head       = head_i;
    q_desc_o.up         = head_i >= prev_i;
    q_desc_o.ovf        = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_LOAD;
      vld_q   <= '0;
      cnt_q   <= '0;
      didx_q  <= '0;
      nb_q    <= '0;
      ne_q    <= '0;
      ovf_q   <= 1'b0;
      bank_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ins_en) begin
        vld_q <= ins_vld;
        cnt_q <= CW'(cnt_q + 1'b1);
      end else if (accept) begin
        ovf_q <= 1'b1;
      end
      if (shift_en) begin
        vld_q <= {1'b0, vld_q[MaxReq-1:1]};
        if (drain_end) begin
          cnt_q  <= '0;
          didx_q <= '0;
          nb_q   <= '0;
          ne_q   <= '0;
          ovf_q  <= 1'b0;
          bank_q <= ~bank_q;
        end else begin
          didx_q <= CW'(didx_q + 1'b1);
          nb_q   <= nb_fin;
          ne_q   <= ne_fin;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_en) begin
      val_q <= ins_val;
    end else if (shift_en) begin
      for (int i = 0; i < MaxReq - 1; i++) begin
        val_q[i] <= val_q[i+1];
      end
    end
  end

endmodule

// ----- rtl/ldsch_desc_q.sv -----
// Two-entry batch queue between front and back; the head entry is held
// until the back end releases it, which also keeps its RAM bank reserved.
// Depends on ldsch_pkg.
module ldsch_desc_q (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ldsch_pkg::desc_t desc_i,
  output logic             full_o,
  output logic             valid_o,
  output ldsch_pkg::desc_t head_o,
  input  logic             release_i
);
  import ldsch_pkg::*;

  desc_t      entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (release_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(release_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_q] <= desc_i;
  end

endmodule

// ----- rtl/ldsch_back.sv -----
// Back end: walks one sorted batch in LOOK order out of its RAM bank and
// forms each move with distance and running total.
// Depends on ldsch_pkg.
module ldsch_back #(
  parameter int unsigned MaxReq = 64,
  localparam int unsigned AW = $clog2(MaxReq)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          d_valid_i,
  input  ldsch_pkg::desc_t              desc_i,
  output logic                          release_o,
  output logic [AW:0]                   ram_raddr_o,
  input  logic [ldsch_pkg::TRACK_W-1:0] ram_rdata_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [ldsch_pkg::TRACK_W-1:0] from_track_o,
  output logic [ldsch_pkg::TRACK_W-1:0] to_track_o,
  output logic [ldsch_pkg::TRACK_W-1:0] distance_o,
  output logic [ldsch_pkg::TOTAL_W-1:0] running_total_o,
  output logic                          last_move_o,
  output logic                          dropped_o
);
  import ldsch_pkg::*;

  back_state_e state_q, state_d;

  logic [CNT_W-1:0]   k_q, total, idx;
  logic [TRACK_W-1:0] head_q, move_dist;
  logic [TRACK_W-1:0] from_q, to_q, dist_q;
  logic [TOTAL_W-1:0] sum_q;
  logic               last_q, drop_q, in_first;

  assign total = desc_i.n_below + desc_i.n_above;

  // First leg: above ascending when moving up, below descending otherwise.
  always_comb begin
    if (desc_i.up) begin
      in_first = k_q < desc_i.n_above;
      idx = in_first ? desc_i.base_above + k_q : total - CNT_W'(1) - k_q;
    end else begin
      in_first = k_q < desc_i.n_below;
      idx = in_first ? desc_i.n_below - CNT_W'(1) - k_q
                     : desc_i.base_above + k_q - desc_i.n_below;
    end
  end

  assign ram_raddr_o = {desc_i.bank, idx[AW-1:0]};
  assign move_dist = (ram_rdata_i > head_q) ? ram_rdata_i - head_q : head_q - ram_rdata_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (d_valid_i && (total != '0)) state_d = B_READ;
      B_READ: state_d = B_WAIT;
      B_WAIT: state_d = B_HOLD;
      B_HOLD: if (pop) state_d = last_q ? B_IDLE : B_WAIT;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    empty     = state_q != B_HOLD;
    release_o = ((state_q == B_IDLE) && d_valid_i && (total == '0)) ||
                ((state_q == B_HOLD) && pop && last_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      k_q     <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_IDLE) begin
        k_q <= '0;
      end else if (state_q == B_WAIT) begin
        last_q <= CNT_W'(k_q + 1'b1) == total;
        k_q    <= CNT_W'(k_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE) begin
      head_q <= desc_i.head;
      sum_q  <= '0;
    end else if (state_q == B_WAIT) begin
      from_q <= head_q;
      to_q   <= ram_rdata_i;
      dist_q <= move_dist;
      sum_q  <= TOTAL_W'(sum_q + move_dist);
      drop_q <= desc_i.ovf;
      head_q <= ram_rdata_i;
    end
  end

  assign from_track_o    = from_q;
  assign to_track_o      = to_q;
  assign distance_o      = dist_q;
  assign running_total_o = sum_q;
  assign last_move_o     = last_q;
  assign dropped_o       = drop_q;

endmodule

// ----- verif/look_disk_scheduler_core_tb.sv -----
// Testbench for look_disk_scheduler_core: queues request batches, predicts the
// LOOK service order of each batch and checks every move the block pops.
// Depends on ldsch_pkg and the core RTL only.
module look_disk_scheduler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ldsch_pkg::*;

  localparam int unsigned MAX_REQ    = 64;
  localparam int unsigned SETTLE_CYC = 2 * MAX_REQ + 40;
  localparam int unsigned LONG_HOLD  = 600;
  localparam int unsigned RAND_ITEMS = 16;
  localparam time         LIMIT_NS   = 1600us;

  typedef struct {
    logic [TRACK_W-1:0] track;
    logic               last;
  } req_t;

  typedef struct {
    logic [TRACK_W-1:0] src;
    logic [TRACK_W-1:0] dst;
    logic [TRACK_W-1:0] span;
    logic [TOTAL_W-1:0] total;
    logic               fin;
    logic               drop;
  } move_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i      = REG_HEAD;
  logic [TRACK_W-1:0]   cfg_wdata_i    = '0;
  logic                 push           = 1'b0;
  logic                 full;
  logic [TRACK_W-1:0]   track_i        = '0;
  logic                 last_request_i = 1'b0;
  logic                 empty;
  logic                 pop            = 1'b0;
  logic [TRACK_W-1:0]   from_track_o;
  logic [TRACK_W-1:0]   to_track_o;
  logic [TRACK_W-1:0]   distance_o;
  logic [TOTAL_W-1:0]   running_total_o;
  logic                 last_move_o;
  logic                 dropped_o;

  look_disk_scheduler_core #(
    .MaxReq(MAX_REQ)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .track_i        (track_i),
    .last_request_i (last_request_i),
    .empty          (empty),
    .pop            (pop),
    .from_track_o   (from_track_o),
    .to_track_o     (to_track_o),
    .distance_o     (distance_o),
    .running_total_o(running_total_o),
    .last_move_o    (last_move_o),
    .dropped_o      (dropped_o)
  );

  initial forever #2 clk_i = ~clk_i;

  // Scheduler copy kept by the testbench
  logic [TRACK_W-1:0] sch_head;
  logic [TRACK_W-1:0] sch_prev;
  logic [TRACK_W-1:0] req_mem [MAX_REQ];
  int unsigned        req_cnt;
  logic [TRACK_W-1:0] head_now;
  logic [22:0]        dist_sum;
  logic               over_seen;

  req_t  pend_q[$];
  move_t moves_q[$];
  int    err_cnt    = 0;
  int    moves_seen = 0;
  int    hold_ticket = 0;

  task automatic note_mismatch(input string what);
    $display("ERROR move %0d: %s", moves_seen, what);
    err_cnt++;
  endtask

  function automatic void add_move(input logic [TRACK_W-1:0] dst, input logic fin);
    move_t              mv;
    logic [TRACK_W-1:0] d;
    d = (dst > head_now) ? dst - head_now : head_now - dst;
    dist_sum = dist_sum + d;
    mv.src   = head_now;
    mv.dst   = dst;
    mv.span  = d;
    mv.total = dist_sum[TOTAL_W-1:0];
    mv.fin   = fin;
    mv.drop  = over_seen;
    moves_q  = {moves_q, mv};
    head_now = dst;
  endfunction

  // Store one request; on the last one emit the LOOK order of the batch.
  function automatic void look_schedule(input logic [TRACK_W-1:0] trk, input logic fin);
    logic [TRACK_W-1:0] srt [MAX_REQ];
    logic [TRACK_W-1:0] key;
    int n, i, j, lo, hi, total, k;
    bit up;
    if (req_cnt < MAX_REQ) begin
      req_mem[req_cnt] = trk;
      req_cnt++;
    end else begin
      over_seen = 1'b1;
    end
    if (!fin) return;
    n = req_cnt;
    for (i = 0; i < n; i++) srt[i] = req_mem[i];
    for (i = 1; i < n; i++) begin
      key = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > key) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    // lo: count below head; hi: first index above head (equal ones are dropped)
    lo = 0;
    while (lo < n && srt[lo] < sch_head) lo++;
    hi = lo;
    while (hi < n && srt[hi] == sch_head) hi++;
    total    = lo + (n - hi);
    head_now = sch_head;
    dist_sum = '0;
    k        = 0;
    up       = (sch_head >= sch_prev);
    if (up) begin
      for (i = hi; i < n; i++) begin k++; add_move(srt[i], k == total); end
      for (i = lo - 1; i >= 0; i--) begin k++; add_move(srt[i], k == total); end
    end else begin
      for (i = lo - 1; i >= 0; i--) begin k++; add_move(srt[i], k == total); end
      for (i = hi; i < n; i++) begin k++; add_move(srt[i], k == total); end
    end
    req_cnt   = 0;
    dist_sum  = '0;
    over_seen = 1'b0;
  endfunction

  // Request driver: bursts of random length with random gaps
  int unsigned burst_left;
  int unsigned gap_left;
  req_t        nxt;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push           <= 1'b0;
      track_i        <= '0;
      last_request_i <= 1'b0;
      burst_left     = $urandom_range(1, 20);
      gap_left       = 0;
      sch_head       = '0;
      sch_prev       = '0;
      req_cnt        = 0;
      head_now       = '0;
      dist_sum       = '0;
      over_seen      = 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_HEAD: sch_head = cfg_wdata_i;
          REG_PREV: sch_prev = cfg_wdata_i;
          default: ;
        endcase
      end
      if (push && !full) look_schedule(track_i, last_request_i);
      if (!(push && full)) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pend_q.size() > 0) begin
          nxt = pend_q.pop_front();
          push           <= 1'b1;
          track_i        <= nxt.track;
          last_request_i <= nxt.last;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Move monitor: checks each popped move, stalls on a pattern of its own
  int unsigned hold_left;
  int          hold_seen;
  int unsigned rx_left;
  int unsigned rx_mode;
  move_t       want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop       <= 1'b0;
      hold_left = 0;
      hold_seen = 0;
      rx_left   = 0;
      rx_mode   = 0;
    end else begin
      if (pop && !empty) begin
        if (moves_q.size() == 0) begin
          note_mismatch($sformatf("unexpected move to %0h", to_track_o));
        end else begin
          want = moves_q.pop_front();
          if (from_track_o !== want.src)
            note_mismatch($sformatf("from_track %0h, want %0h", from_track_o, want.src));
          if (to_track_o !== want.dst)
            note_mismatch($sformatf("to_track %0h, want %0h", to_track_o, want.dst));
          if (distance_o !== want.span)
            note_mismatch($sformatf("distance %0h, want %0h", distance_o, want.span));
          if (running_total_o !== want.total)
            note_mismatch($sformatf("running_total %0h, want %0h", running_total_o,
                                    want.total));
          if (last_move_o !== want.fin)
            note_mismatch($sformatf("last_move %0b, want %0b", last_move_o, want.fin));
          if (dropped_o !== want.drop)
            note_mismatch($sformatf("dropped %0b, want %0b", dropped_o, want.drop));
        end
        moves_seen++;
      end
      if (hold_seen != hold_ticket) begin
        hold_seen = hold_ticket;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_left = $urandom_range(10, 60);
        end
        rx_left--;
        case (rx_mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          default: pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic write_regs(input logic [TRACK_W-1:0] hd, input logic [TRACK_W-1:0] pv);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_HEAD;
    cfg_wdata_i <= hd;
    @(posedge clk_i);
    cfg_idx_i   <= REG_PREV;
    cfg_wdata_i <= pv;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold the sender until every item is in and every move is out, then settle.
  task automatic wait_idle();
    while (pend_q.size() != 0 || push || moves_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic queue_req(input logic [TRACK_W-1:0] trk, input logic fin);
    req_t r;
    r.track = trk;
    r.last  = fin;
    pend_q  = {pend_q, r};
  endtask

  function automatic logic [TRACK_W-1:0] pick_track(input logic [TRACK_W-1:0] hd,
                                                     input logic [TRACK_W-1:0] prv);
    case ($urandom_range(0, 9))
      0:       return hd;
      1:       return prv;
      2:       return '0;
      3:       return '1;
      4, 5:    return TRACK_W'(hd + $urandom_range(0, 40) - 20);
      default: return TRACK_W'($urandom_range(0, 65535));
    endcase
  endfunction

  int items_sent = 0;

  task automatic queue_batch(input int n, input bit eq_only);
    logic [TRACK_W-1:0] t;
    int i;
    t = TRACK_W'($urandom_range(0, 65535));
    for (i = 0; i < n; i++) begin
      t = eq_only ? sch_head : pick_track(sch_head, t);
      queue_req(t, i == n - 1);
    end
    items_sent += n;
  endtask

  function automatic logic [TRACK_W-1:0] pick_reg();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return TRACK_W'($urandom_range(0, 65535));
    endcase
  endfunction

  logic [TRACK_W-1:0] rh, rp;

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset registers: head 0, upward; head-equal, top track and a duplicate
    queue_req(16'h0000, 1'b0);
    queue_req(16'hFFFF, 1'b0);
    queue_req(16'h0001, 1'b0);
    queue_req(16'hFFFF, 1'b0);
    queue_req(16'h8000, 1'b1);
    wait_idle();

    // head at the top: everything else lies below
    write_regs(16'hFFFF, 16'h0000);
    queue_req(16'hFFFF, 1'b0);
    queue_req(16'h0000, 1'b0);
    queue_req(16'h7FFF, 1'b0);
    queue_req(16'h1234, 1'b1);
    wait_idle();

    // downward sweep around the middle
    write_regs(16'h8000, 16'hFFFF);
    queue_req(16'hFFFF, 1'b0);
    queue_req(16'h0000, 1'b0);
    queue_req(16'h8000, 1'b0);
    queue_req(16'h8001, 1'b0);
    queue_req(16'h7FFF, 1'b0);
    queue_req(16'h0001, 1'b0);
    queue_req(16'hAAAA, 1'b1);
    wait_idle();

    // equal registers sweep upward; a batch with no moves, then a single move
    write_regs(16'h5555, 16'h5555);
    queue_req(16'h5555, 1'b1);
    queue_req(16'h2AAA, 1'b1);
    wait_idle();

    // stall the receiver while an overflowing batch and three more stream in;
    // the last one is offered while both banks are taken
    write_regs(pick_reg(), pick_reg());
    hold_ticket++;
    queue_batch($urandom_range(MAX_REQ + 1, MAX_REQ + 4), 1'b0);
    queue_batch(4, 1'b0);
    queue_batch(4, 1'b0);
    queue_batch(4, 1'b0);
    wait_idle();

    // overflowing batch in which every request equals the head
    write_regs(TRACK_W'($urandom_range(0, 65535)), TRACK_W'($urandom_range(0, 65535)));
    queue_batch(MAX_REQ + 1, 1'b1);
    wait_idle();

    items_sent = 0;
    while (items_sent < RAND_ITEMS) begin
      rh = pick_reg();
      case ($urandom_range(0, 3))
        0:       rp = rh;
        default: rp = pick_reg();
      endcase
      write_regs(rh, rp);
      repeat ($urandom_range(1, 3)) queue_batch($urandom_range(1, 10), 1'b0);
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("look_disk_scheduler_core: match");
    end else begin
      $display("look_disk_scheduler_core: mismatch");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("look_disk_scheduler_core: mismatch");
    $finish;
  end

endmodule
